[rtl/dost_pkg.sv]
// ---------------------------------------------------------------------------
// dost_pkg
// Shared types and constants for the door opener state tracker.
// ---------------------------------------------------------------------------
package dost_pkg;

    localparam int unsigned POSITION_FRAC_BITS_DEFAULT = 16;

    localparam int unsigned STEP_WIDTH   = 17;
    localparam int unsigned WINDOW_WIDTH = 24;
    localparam int unsigned CFG_ADDR_W   = 1;
    localparam int unsigned CFG_DATA_W   = 24;
    localparam int unsigned OP_WIDTH     = 4;
    localparam int unsigned PCT_WIDTH    = 7;

    localparam logic [STEP_WIDTH-1:0]   STEP_RESET   = 17'd55;
    localparam logic [WINDOW_WIDTH-1:0] WINDOW_RESET = 24'd6000;
    localparam logic [PCT_WIDTH-1:0]    PERCENT_SCALE = 7'd100;

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_STEP   = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_WINDOW = 1'd1;

    // item opcodes
    localparam logic [OP_WIDTH-1:0] OP_TICK     = 4'd0;
    localparam logic [OP_WIDTH-1:0] OP_WALL_BTN = 4'd1;
    localparam logic [OP_WIDTH-1:0] OP_PAIR_BTN = 4'd2;
    localparam logic [OP_WIDTH-1:0] OP_OBSTRUCT = 4'd3;
    localparam logic [OP_WIDTH-1:0] OP_REED     = 4'd4;
    localparam logic [OP_WIDTH-1:0] OP_OPEN     = 4'd5;
    localparam logic [OP_WIDTH-1:0] OP_CLOSE    = 4'd6;
    localparam logic [OP_WIDTH-1:0] OP_STOP     = 4'd7;
    localparam logic [OP_WIDTH-1:0] OP_TOGGLE   = 4'd8;

    typedef enum logic [2:0] {
        MODE_CLOSED  = 3'd0,
        MODE_OPENING = 3'd1,
        MODE_OPEN    = 3'd2,
        MODE_CLOSING = 3'd3,
        MODE_STOPPED = 3'd4
    } door_mode_t;

    typedef struct packed {
        logic [OP_WIDTH-1:0] op;
        logic                level;
    } item_t;

    // packed so door_state lands in the lowest bits
    typedef struct packed {
        logic                 cmd_status;
        logic                 changed;
        logic                 warn_out;
        logic                 pulse_out;
        logic                 obstructed;
        logic                 pairing_active;
        logic [PCT_WIDTH-1:0] open_percent;
        logic [2:0]           door_state;
    } result_t;

endpackage

[rtl/dost_in_stage.sv]
// ---------------------------------------------------------------------------
// dost_in_stage
// Input register: holds one beat until the core consumes it.
// ---------------------------------------------------------------------------
module dost_in_stage (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  dost_pkg::item_t in_item,
    output logic            item_valid,
    output dost_pkg::item_t item,
    input  logic            take
);
    import dost_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    assign in_ready   = !valid_reg || take;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

[rtl/dost_core.sv]
// ---------------------------------------------------------------------------
// dost_core
// Door state registers and the combinational next-state update for one item.
// ---------------------------------------------------------------------------
module dost_core #(
    parameter int unsigned POSITION_FRAC_BITS = dost_pkg::POSITION_FRAC_BITS_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                fire,
    input  dost_pkg::item_t                     item,
    input  logic [dost_pkg::STEP_WIDTH-1:0]     step,
    input  logic [dost_pkg::WINDOW_WIDTH-1:0]   window,
    output dost_pkg::result_t                   result
);
    import dost_pkg::*;

    localparam int unsigned F      = POSITION_FRAC_BITS;
    localparam int unsigned POS_W  = F + 1;
    localparam int unsigned SUM_W  = ((POS_W > STEP_WIDTH) ? POS_W : STEP_WIDTH) + 1;
    localparam int unsigned PROD_W = POS_W + PCT_WIDTH;
    localparam logic [POS_W-1:0]  FULL_POS = {1'b1, {F{1'b0}}};
    localparam logic [PROD_W-1:0] HALF_POS = PROD_W'(1) << (F - 1);

    function automatic logic [PCT_WIDTH-1:0] pct(input logic [POS_W-1:0] p);
        logic [PROD_W-1:0] prod;
        prod = PROD_W'(p) * PROD_W'(PERCENT_SCALE) + HALF_POS;
        return prod[F +: PCT_WIDTH];
    endfunction

    door_mode_t              mode_reg, mode_next;
    logic                    last_open_reg, last_open_next;
    logic [POS_W-1:0]        pos_reg, pos_next;
    logic [WINDOW_WIDTH-1:0] pair_reg, pair_next;
    logic                    blocked_reg, blocked_next;

    logic             can_open, can_close, can_stop;
    logic             tog_open, tog_close;
    logic             req_open, req_close, req_stop;
    logic             pulse, warn, notified, refused;
    logic             tick_note;
    logic [SUM_W-1:0] pos_sum, pos_diff;
    logic [PCT_WIDTH-1:0] pct_before, pct_after;

    assign can_open  = (mode_reg != MODE_OPEN) && (mode_reg != MODE_OPENING);
    assign can_close = (mode_reg != MODE_CLOSED) && (mode_reg != MODE_CLOSING);
    assign can_stop  = (mode_reg == MODE_OPENING) || (mode_reg == MODE_CLOSING);
    assign tog_open  = (mode_reg == MODE_CLOSED) || (mode_reg == MODE_STOPPED && !last_open_reg);
    assign tog_close = (mode_reg == MODE_OPEN) || (mode_reg == MODE_STOPPED && last_open_reg);

    assign pos_sum  = SUM_W'(pos_reg) + SUM_W'(step);
    assign pos_diff = SUM_W'(pos_reg) - SUM_W'(step);

    // open / close / stop requests from commands and toggles
    always_comb
    begin
        req_open  = 1'b0;
        req_close = 1'b0;
        req_stop  = 1'b0;
        refused   = 1'b0;
        unique case (item.op)
            OP_WALL_BTN:
            begin
                req_open  = tog_open;
                req_close = tog_close;
                req_stop  = can_stop;
            end
            OP_OPEN:
            begin
                req_open = 1'b1;
            end
            OP_CLOSE:
            begin
                refused   = blocked_reg;
                req_close = !blocked_reg;
            end
            OP_STOP:
            begin
                req_stop = 1'b1;
            end
            OP_TOGGLE:
            begin
                refused   = blocked_reg && tog_close;
                req_open  = tog_open;
                req_close = tog_close && !blocked_reg;
                req_stop  = can_stop;
            end
            default:
            begin
                refused = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        mode_next      = mode_reg;
        last_open_next = last_open_reg;
        pos_next       = pos_reg;
        pair_next      = pair_reg;
        blocked_next   = blocked_reg;
        pulse          = 1'b0;
        warn           = 1'b0;
        notified       = 1'b0;

        if (req_open && can_open)
        begin
            pulse          = 1'b1;
            mode_next      = MODE_OPENING;
            last_open_next = 1'b1;
            notified       = 1'b1;
        end
        else if (req_close && can_close)
        begin
            pulse          = 1'b1;
            warn           = 1'b1;
            mode_next      = MODE_CLOSING;
            last_open_next = 1'b0;
            notified       = 1'b1;
        end
        else if (req_stop && can_stop)
        begin
            pulse     = 1'b1;
            mode_next = MODE_STOPPED;
            notified  = 1'b1;
        end

        unique case (item.op)
            OP_TICK:
            begin
                if (pair_reg != '0)
                begin
                    pair_next = pair_reg - WINDOW_WIDTH'(1);
                end
                if (mode_reg == MODE_OPENING)
                begin
                    if (pos_sum >= SUM_W'(FULL_POS))
                    begin
                        pos_next  = FULL_POS;
                        mode_next = MODE_OPEN;
                    end
                    else
                    begin
                        pos_next = pos_sum[POS_W-1:0];
                    end
                end
                else if (mode_reg == MODE_CLOSING)
                begin
                    if (blocked_reg)
                    begin
                        mode_next      = MODE_OPENING;
                        last_open_next = 1'b1;
                    end
                    else if (SUM_W'(step) >= SUM_W'(pos_reg))
                    begin
                        pos_next  = '0;
                        mode_next = MODE_CLOSED;
                    end
                    else
                    begin
                        pos_next = pos_diff[POS_W-1:0];
                    end
                end
            end
            OP_PAIR_BTN:
            begin
                pair_next = window;
                notified  = 1'b1;
            end
            OP_OBSTRUCT:
            begin
                blocked_next = item.level;
                notified     = (blocked_reg != item.level);
            end
            OP_REED:
            begin
                if (item.level)
                begin
                    if (mode_reg != MODE_CLOSED || pos_reg != '0)
                    begin
                        mode_next = MODE_CLOSED;
                        pos_next  = '0;
                        notified  = 1'b1;
                    end
                end
                else if (mode_reg == MODE_CLOSED)
                begin
                    mode_next      = MODE_OPENING;
                    last_open_next = 1'b1;
                    notified       = 1'b1;
                end
            end
            default:
            begin
                blocked_next = blocked_reg;
            end
        endcase
    end

    assign pct_before = pct(pos_reg);
    assign pct_after  = pct(pos_next);

    // a tick reports whether the visible status moved
    assign tick_note = (mode_next != mode_reg) || (pct_after != pct_before)
                    || ((pair_next != '0) != (pair_reg != '0));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_CLOSED;
            last_open_reg <= 1'b0;
            pos_reg       <= '0;
            pair_reg      <= '0;
            blocked_reg   <= 1'b0;
        end
        else if (fire)
        begin
            mode_reg      <= mode_next;
            last_open_reg <= last_open_next;
            pos_reg       <= pos_next;
            pair_reg      <= pair_next;
            blocked_reg   <= blocked_next;
        end
    end

    always_comb
    begin
        result.door_state     = mode_next;
        result.open_percent   = pct_after;
        result.pairing_active = (pair_next != '0);
        result.obstructed     = blocked_next;
        result.pulse_out      = pulse;
        result.warn_out       = warn;
        result.changed        = (item.op == OP_TICK) ? tick_note : notified;
        result.cmd_status     = refused;
    end

endmodule

[rtl/door_opener_state_tracker_top.sv]
// ---------------------------------------------------------------------------
// door_opener_state_tracker_top
// Door opener state tracker: stream in events, stream out one status per event.
// ---------------------------------------------------------------------------
// Input beats carry the event code on s_axis_tuser and the sensor level in
// bit 0 of s_axis_tdata. Every input beat yields exactly one output beat on
// m_axis with the door status after the event, the button pulse, the closing
// warning, the changed flag and the command refusal flag.
// From input accept to output valid the beat passes the input register, which
// captures it, and then the result register, which takes the state update
// when the receiver is ready.
// Throughput is one beat per clock while m_axis_tready stays high; the state
// update is a single pass of next-state logic, so back-to-back events are
// tracked without gaps. When the receiver stalls the result register holds
// and the input register absorbs one more beat before s_axis_tready drops.
// Reset clears the door to closed, position 0, pairing window idle, sensor
// clear, and loads step_per_tick = 55 and pairing_window_ticks = 6000.
// Configuration writes (cfg_addr 0 step, 1 window) take effect at once and
// should only be issued while no beat is in flight.
// ---------------------------------------------------------------------------
module door_opener_state_tracker_top #(
    parameter int unsigned POSITION_FRAC_BITS = dost_pkg::POSITION_FRAC_BITS_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [7:0]                        s_axis_tdata,  // [0] level
    input  logic [dost_pkg::OP_WIDTH-1:0]     s_axis_tuser,  // [3:0] op
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [2:0] door_state, [9:3] open_percent, [10] pairing_active, [11] obstructed,
    // [12] pulse_out, [13] warn_out, [14] changed, [15] cmd_status
    output logic [15:0]                       m_axis_tdata,
    input  logic                              cfg_wr_en,
    input  logic [dost_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [dost_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
    import dost_pkg::*;

    logic [STEP_WIDTH-1:0]   step_reg;
    logic [WINDOW_WIDTH-1:0] window_reg;

    item_t   in_item, item;
    logic    item_valid;
    logic    out_ready;
    logic    fire;
    result_t result;
    result_t out_reg;
    logic    out_valid_reg, out_valid_next;

    assign in_item.op    = s_axis_tuser;
    assign in_item.level = s_axis_tdata[0];

    assign out_ready = !out_valid_reg || m_axis_tready;
    assign fire      = item_valid && out_ready;

    dost_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_item    (in_item),
        .item_valid (item_valid),
        .item       (item),
        .take       (fire)
    );

    dost_core #(
        .POSITION_FRAC_BITS (POSITION_FRAC_BITS)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .item   (item),
        .step   (step_reg),
        .window (window_reg),
        .result (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg   <= STEP_RESET;
            window_reg <= WINDOW_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_addr)
                REG_STEP:   step_reg   <= cfg_wdata[STEP_WIDTH-1:0];
                REG_WINDOW: window_reg <= cfg_wdata[WINDOW_WIDTH-1:0];
                default:    step_reg   <= step_reg;
            endcase
        end
    end

    assign out_valid_next = out_ready ? item_valid : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_reg <= result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_reg;

endmodule
